>>> src/bit_pkg.sv
// Shared types and constants for the binary image thinning block.
`timescale 1ns / 1ps
`default_nettype none
package bit_pkg;
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;
   localparam logic       KIND_READ = 1'b0;
   localparam logic       KIND_RUN  = 1'b1;
   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic       result_kind;
      logic       skeleton_bit;
      logic [15:0] pass_count;
   } rsp_type;

   // Zhang-Suen removal test on the ring P2..P9 (bit 0 is P2, clockwise).
   function automatic logic removable(input logic [7:0] p, input logic second);
      logic [3:0] sum;
      logic [3:0] trans;
      logic       ok;
      sum = 4'd0;
      trans = 4'd0;
      for (int k = 0; k < 8; k++) begin
         sum = sum + {3'd0, p[k]};
         if (!p[k] && p[(k + 1) % 8]) trans = trans + 4'd1;
      end
      if (!second) ok = !(p[0] & p[2] & p[4]) && !(p[2] & p[4] & p[6]);
      else ok = !(p[0] & p[2] & p[6]) && !(p[0] & p[4] & p[6]);
      return (trans == 4'd1) && (sum >= 4'd2) && (sum <= 4'd6) && ok;
   endfunction
endpackage
`default_nettype wire

>>> src/bit_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface bit_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] pixel_row;
   logic [7:0] pixel_col;
   logic [7:0] pixel_value;
   modport source (output valid, opcode, pixel_row, pixel_col, pixel_value, input ready);
   modport sink (input valid, opcode, pixel_row, pixel_col, pixel_value, output ready);
endinterface

interface bit_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic        skeleton_bit;
   logic [15:0] pass_count;
   modport source (output valid, result_kind, skeleton_bit, pass_count, input ready);
   modport sink (input valid, result_kind, skeleton_bit, pass_count, output ready);
endinterface

interface bit_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/binary_image_thinning.sv
// Top level of the binary image thinning block.
//  channel | dir | fields
//  req     | in  | opcode, pixel_row, pixel_col, pixel_value
//  rsp     | out | result_kind, skeleton_bit, pass_count
//  csr     | in  | index, data (width, height)
// A write is done when it is taken; a read answers once the response register is
// free. A run marks each inner pixel per subiteration from nine window reads and a
// judge step on the single image port, then sweeps with a mark read and a clear.
// Reset is synchronous, clears control state and sets both size registers to 256.
// A stalled response holds the controller in its finishing state.
`timescale 1ns / 1ps
`default_nettype none
module binary_image_thinning #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input wire logic clock,
   input wire logic reset,
   bit_req_if.sink  req,
   bit_rsp_if.source rsp,
   bit_csr_if.sink  csr
);
   import bit_pkg::*;
   logic [8:0] w_ff, h_ff;
   logic idle, scan_en, second, pix_we, mark_we, run_done, read_done, marked, rd_bit;
   logic [$clog2(MAX_HEIGHT)-1:0] scan_row;
   logic [$clog2(MAX_WIDTH)-1:0]  scan_col;
   logic [15:0] cnt;
   logic rsp_v_ff; rsp_type rsp_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin w_ff <= 9'd256; h_ff <= 9'd256; end
      else if (csr.valid) begin
         if (csr.index == CSR_WIDTH) w_ff <= csr.data;
         if (csr.index == CSR_HEIGHT) h_ff <= csr.data;
      end
   end

   assign req.ready = idle;
   wire fire = req.valid && req.ready;

   bit_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
      .clock(clock), .reset(reset), .opcode(req.opcode), .req_fire(fire),
      .image_width(w_ff), .image_height(h_ff), .rsp_busy(rsp_v_ff), .marked(marked),
      .idle(idle), .pix_we(pix_we), .mark_we(mark_we), .scan_row(scan_row),
      .scan_col(scan_col), .scan_en(scan_en), .second(second), .run_done(run_done),
      .pass_count(cnt), .read_done(read_done));

   bit_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock(clock), .reset(reset), .req_fire(fire), .opcode(req.opcode),
      .pixel_row(req.pixel_row), .pixel_col(req.pixel_col), .pixel_value(req.pixel_value),
      .idle(idle), .scan_en(scan_en), .scan_row(scan_row), .scan_col(scan_col),
      .second(second), .ctrl_we(pix_we), .mark_we(mark_we), .marked(marked),
      .rd_bit(rd_bit));

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (run_done || read_done) rsp_v_ff <= 1'b1;
      else if (rsp.ready) rsp_v_ff <= 1'b0;
      if (run_done) rsp_ff <= '{KIND_RUN, 1'b0, cnt};
      else if (read_done) rsp_ff <= '{KIND_READ, rd_bit, 16'd0};
   end
   assign rsp.valid = rsp_v_ff;
   assign rsp.result_kind = rsp_ff.result_kind;
   assign rsp.skeleton_bit = rsp_ff.skeleton_bit;
   assign rsp.pass_count = rsp_ff.pass_count;
endmodule
`default_nettype wire

>>> src/bit_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bit_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

>>> src/bit_ctrl.sv
// Controller: sequences pixel reads, writes and the thinning sweeps.
`timescale 1ns / 1ps
`default_nettype none
module bit_ctrl #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [1:0] opcode,
   input  wire logic       req_fire,
   input  wire logic [8:0] image_width,
   input  wire logic [8:0] image_height,
   input  wire logic       rsp_busy,
   input  wire logic       marked,
   output      logic       idle,
   output      logic       pix_we,
   output      logic       mark_we,
   output      logic [$clog2(MAX_HEIGHT)-1:0] scan_row,
   output      logic [$clog2(MAX_WIDTH)-1:0]  scan_col,
   output      logic       scan_en,
   output      logic       second,
   output      logic       run_done,
   output      logic [15:0] pass_count,
   output      logic       read_done
);
   import bit_pkg::*;
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_RD = 3'd2, S_FETCH = 3'd3,
      S_JUDGE = 3'd4, S_DONE = 3'd5, S_MRD = 3'd6, S_CLR = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [3:0] step_ff, step_in;
   logic second_ff, second_in, chg_ff, chg_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [12:0] w, h;
   logic col_last, row_last;

   always_comb begin
      w = {4'd0, image_width};
      h = {4'd0, image_height};
      if (w == 13'd0) w = 13'd1;
      if (w > 13'(MAX_WIDTH)) w = 13'(MAX_WIDTH);
      if (h == 13'd0) h = 13'd1;
      if (h > 13'(MAX_HEIGHT)) h = 13'(MAX_HEIGHT);
   end

   // Each subiteration first marks every inner pixel from the unchanged image,
   // then sweeps again and clears the marked ones. A mark reads nine pixels, one
   // per cycle, and then judges; a clear reads the mark and then writes.
   always_comb begin
      state_in = state_ff; row_in = row_ff; col_in = col_ff; step_in = step_ff;
      second_in = second_ff; chg_in = chg_ff; cnt_in = cnt_ff;
      col_last = 13'(col_ff) + 13'd2 >= w;
      row_last = 13'(row_ff) + 13'd2 >= h;
      case (state_ff)
         S_IDLE: if (req_fire) begin
            if (opcode == OP_READ) state_in = S_READ;
            else if (opcode == OP_RUN) begin
               cnt_in = 16'd1; second_in = 1'b0; chg_in = 1'b0;
               row_in = RW'(1); col_in = CW'(1); step_in = 4'd0;
               state_in = (w < 13'd3 || h < 13'd3) ? S_DONE : S_FETCH;
            end
         end
         S_READ: state_in = S_RD;
         S_RD: if (!rsp_busy) state_in = S_IDLE;
         S_FETCH: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd9) begin step_in = 4'd0; state_in = S_JUDGE; end
         end
         S_JUDGE: begin
            state_in = S_FETCH;
            if (!col_last) col_in = col_ff + CW'(1);
            else begin
               col_in = CW'(1);
               if (!row_last) row_in = row_ff + RW'(1);
               else begin
                  row_in = RW'(1);
                  state_in = S_MRD;
               end
            end
         end
         S_MRD: state_in = S_CLR;
         S_CLR: begin
            state_in = S_MRD;
            if (marked) chg_in = 1'b1;
            if (!col_last) col_in = col_ff + CW'(1);
            else begin
               col_in = CW'(1);
               if (!row_last) row_in = row_ff + RW'(1);
               else begin
                  row_in = RW'(1);
                  state_in = S_FETCH;
                  if (!second_ff) second_in = 1'b1;
                  else begin
                     second_in = 1'b0;
                     if (chg_in) begin
                        chg_in = 1'b0;
                        if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 16'd1;
                     end else state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: if (!rsp_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; step_ff <= 4'd0; second_ff <= 1'b0; chg_ff <= 1'b0;
         cnt_ff <= 16'd0; row_ff <= RW'(1); col_ff <= CW'(1);
      end else begin
         state_ff <= state_in; step_ff <= step_in; second_ff <= second_in;
         chg_ff <= chg_in; cnt_ff <= cnt_in; row_ff <= row_in; col_ff <= col_in;
      end
   end

   assign idle = state_ff == S_IDLE;
   assign scan_row = row_ff;
   assign scan_col = col_ff;
   assign scan_en = state_ff == S_FETCH;
   assign second = second_ff;
   assign mark_we = state_ff == S_JUDGE;
   assign pix_we = state_ff == S_CLR && marked;
   assign run_done = state_ff == S_DONE && !rsp_busy;
   assign read_done = state_ff == S_RD && !rsp_busy;
   assign pass_count = cnt_ff;

   property p_start;
      @(posedge clock) disable iff (reset) (idle && req_fire && opcode == OP_RUN) |=> !idle;
   endproperty
   a_start: assert property (p_start) else $error("run did not leave idle");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> cnt_ff != 16'd0) else $error("zero pass count");
   a_we: assert property (@(posedge clock) disable iff (reset)
      pix_we |-> !idle) else $error("write in idle");
endmodule
`default_nettype wire

>>> src/bit_dp.sv
// Datapath: pixel memory with mark memory, window fetch and removal test.
`timescale 1ns / 1ps
`default_nettype none
module bit_dp #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic       req_fire,
   input  wire logic [1:0] opcode,
   input  wire logic [7:0] pixel_row,
   input  wire logic [7:0] pixel_col,
   input  wire logic [7:0] pixel_value,
   input  wire logic       idle,
   input  wire logic       scan_en,
   input  wire logic [$clog2(MAX_HEIGHT)-1:0] scan_row,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  scan_col,
   input  wire logic       second,
   input  wire logic       ctrl_we,
   input  wire logic       mark_we,
   output      logic       marked,
   output      logic       rd_bit
);
   import bit_pkg::*;
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   // The image memory holds the current image; the mark memory holds the removal
   // marks of the subiteration in progress.
   logic [AW-1:0] img_addr, req_addr, scan_addr;
   logic img_we, img_wd, img_rd, mark_rd, removed, wr_ok;
   logic [3:0] step_ff;
   logic [8:0] win_ff;
   logic inr_ff, rd_pend_ff, rd_ff;
   logic [RW-1:0] r_a; logic [CW-1:0] c_a;

   bit_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_img (
      .clock(clock), .we(img_we), .addr(img_addr), .wdata(img_wd), .rdata(img_rd));
   bit_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_mark (
      .clock(clock), .we(mark_we), .addr(scan_addr), .wdata(removed), .rdata(mark_rd));

   assign wr_ok = 32'(pixel_row) < MAX_HEIGHT && 32'(pixel_col) < MAX_WIDTH;
   assign req_addr = AW'(32'(pixel_row) * MAX_WIDTH + 32'(pixel_col));
   assign scan_addr = AW'(32'(scan_row) * MAX_WIDTH + 32'(scan_col));

   // Steps 0..7 read the neighbors and step 8 the center pixel; each result lands in the next cycle.
   always_comb begin
      r_a = scan_row; c_a = scan_col;
      case (step_ff)
         4'd0: begin r_a = scan_row - RW'(1); end
         4'd1: begin r_a = scan_row - RW'(1); c_a = scan_col + CW'(1); end
         4'd2: begin c_a = scan_col + CW'(1); end
         4'd3: begin r_a = scan_row + RW'(1); c_a = scan_col + CW'(1); end
         4'd4: begin r_a = scan_row + RW'(1); end
         4'd5: begin r_a = scan_row + RW'(1); c_a = scan_col - CW'(1); end
         4'd6: begin c_a = scan_col - CW'(1); end
         4'd7: begin r_a = scan_row - RW'(1); c_a = scan_col - CW'(1); end
         default: ;
      endcase
   end

   assign removed = win_ff[8] && removable(win_ff[7:0], second);
   assign marked = mark_rd;
   always_comb begin
      img_we = 1'b0; img_wd = 1'b0;
      img_addr = req_addr;
      if (scan_en) img_addr = AW'(32'(r_a) * MAX_WIDTH + 32'(c_a));
      else if (ctrl_we) begin
         img_addr = scan_addr;
         img_we = 1'b1;
      end else if (idle && req_fire && opcode == OP_WRITE && wr_ok) begin
         img_we = 1'b1; img_wd = pixel_value != 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 4'd0; rd_pend_ff <= 1'b0;
      end else begin
         if (scan_en) step_ff <= (step_ff == 4'd9) ? 4'd0 : step_ff + 4'd1;
         else step_ff <= 4'd0;
         rd_pend_ff <= idle && req_fire && opcode == OP_READ;
      end
      if (scan_en && step_ff != 4'd0) win_ff <= {img_rd, win_ff[8:1]};
      if (idle && req_fire) inr_ff <= wr_ok;
      // The read data is held here while the response waits.
      if (rd_pend_ff) rd_ff <= inr_ff && img_rd;
   end
   assign rd_bit = rd_ff;
endmodule
`default_nettype wire
